### sv/arsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsp_pkg
// Shared types and constants of the asset record stream parser: the field
// tags, which also serve as parser phases, and the per-byte result record.
// ----------------------------------------------------------------------------
package arsp_pkg;

  // Field tag of a byte; the parser phase uses the same encoding.
  typedef enum logic [3:0] {
    TAG_ID       = 4'd0,
    TAG_SYMLEN   = 4'd1,
    TAG_SYMBOL   = 4'd2,
    TAG_DECIMALS = 4'd3,
    TAG_CUSTODY  = 4'd4,
    TAG_REFLEN   = 4'd5,
    TAG_REF      = 4'd6,
    TAG_PAUSED   = 4'd7,
    TAG_EXCESS   = 4'd8
  } arsp_tag_e;

  // Fixed layout constants.
  localparam int unsigned IdBytes  = 32;
  localparam int unsigned IdxW     = 9;
  localparam int unsigned IdxMax   = 511;
  localparam int unsigned SymCntW  = 5;
  localparam int unsigned RefCntW  = 10;
  localparam int unsigned TdataOutW = 56;

  // Result for one parsed byte.
  typedef struct packed {
    arsp_tag_e           tag;
    logic [IdxW-1:0]     index;
    logic [7:0]          data;
    logic                done;
    logic                ok;
    logic [SymCntW-1:0]  sym_count;
    logic [7:0]          decimals;
    logic [7:0]          custody;
    logic [RefCntW-1:0]  ref_count;
    logic                paused;
  } arsp_result_t;

endpackage
`default_nettype wire

### sv/asset_record_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asset_record_stream_parser
// Byte-serial parser for a serialized asset record.
//
// Usage: record bytes arrive on the slave stream, one byte per transfer in
// s_axis_tdata, with s_axis_tlast on the final byte of a record. For every
// byte the master stream returns one transfer: the field tag in
// m_axis_tuser, the byte's index in its field and the byte itself in
// m_axis_tdata, and tlast copied from the input. On the final byte
// m_axis_tdata also carries record_ok and, for a clean record, the symbol
// length, decimals, custody kind, reference length and paused flag.
// An input register, then a result register, lie between input transfer
// and result transfer. One byte per cycle is sustained while results are
// taken: the parser state advances in a single pass as the byte moves
// between the two registers. After reset the parser expects the identifier
// field, and every final byte returns it there. When the receiver stalls,
// the result register holds and one more byte waits in the input register;
// then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module asset_record_stream_parser
  import arsp_pkg::*;
#(
  parameter int unsigned SYMBOL_MAX = 16,
  parameter int unsigned REF_MAX    = 512
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
  input  wire logic                  s_axis_tlast,  // last_byte
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [8:0] field_index, [16:9] byte_out, [17] record_ok, [22:18] symbol_count,
  // [30:23] decimals_out, [38:31] custody_out, [48:39] reference_count,
  // [49] paused_out, [55:50] zero
  output logic [TdataOutW-1:0]       m_axis_tdata,
  output logic [3:0]                 m_axis_tuser,  // [3:0] field_tag
  output logic                       m_axis_tlast   // record_done
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  arsp_result_t out_res_q;
  arsp_result_t res;
  logic         out_ready;
  logic         advance;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Parser state and per-byte logic.
  arsp_parser #(
    .SYMBOL_MAX (SYMBOL_MAX),
    .REF_MAX    (REF_MAX)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.tag;
  assign m_axis_tlast  = out_res_q.done;
  assign m_axis_tdata  = {6'd0, out_res_q.paused, out_res_q.ref_count,
                          out_res_q.custody, out_res_q.decimals,
                          out_res_q.sym_count, out_res_q.ok,
                          out_res_q.data, out_res_q.index};

  // A clean record is only reported on the final byte, in the paused field.
  a_ok_on_paused_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tlast && (m_axis_tuser == TAG_PAUSED))
    else $error("record_ok outside the final paused byte");

  // Decoded values stay zero unless the record is clean.
  a_zero_when_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[17] |-> (m_axis_tdata[49:18] == 32'd0))
    else $error("decoded fields nonzero without record_ok");

  // Identifier bytes are indexed within the identifier length.
  a_id_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == TAG_ID) |-> (m_axis_tdata[8:0] < 9'(IdBytes)))
    else $error("identifier index out of range");

endmodule
`default_nettype wire

### sv/arsp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsp_parser
// Record parser state and its single-pass next-state logic. Each step
// consumes one byte, advances the phase and position, checks the field
// and forms the tagged result for that byte.
// ----------------------------------------------------------------------------
module arsp_parser
  import arsp_pkg::*;
#(
  parameter int unsigned SYMBOL_MAX = 16,
  parameter int unsigned REF_MAX    = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  input  wire logic         last_i,
  output arsp_result_t      result_o
);

  localparam int unsigned SymW = $clog2(SYMBOL_MAX + 1);
  localparam int unsigned RefW = $clog2(REF_MAX + 1);
  localparam int unsigned PosA = (SymW > IdxW) ? SymW : IdxW;
  localparam int unsigned PosW = (RefW > PosA) ? RefW : PosA;

  arsp_tag_e           phase_q, phase_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW:0]       pos_inc;
  logic [SymW-1:0]     sym_len_q, sym_len_d;
  logic [7:0]          ref_high_q, ref_high_d;
  logic [RefW-1:0]     ref_len_q, ref_len_d;
  logic [7:0]          decimals_q, decimals_d;
  logic [7:0]          custody_q, custody_d;
  logic                paused_q, paused_d;
  logic                fault_q, fault_d;
  logic [15:0]         ref_value;
  logic                char_ok;
  logic                ok;

  assign pos_inc   = {1'b0, pos_q} + 1'b1;
  assign ref_value = {ref_high_q, byte_i};
  assign char_ok   = ((byte_i >= 8'h41) && (byte_i <= 8'h5A)) ||
                     ((byte_i >= 8'h30) && (byte_i <= 8'h39));

  // Next state for one byte.
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    sym_len_d  = sym_len_q;
    ref_high_d = ref_high_q;
    ref_len_d  = ref_len_q;
    decimals_d = decimals_q;
    custody_d  = custody_q;
    paused_d   = paused_q;
    fault_d    = fault_q;
    case (phase_q)
      TAG_ID: begin
        if (pos_inc >= (PosW+1)'(IdBytes)) begin
          phase_d = TAG_SYMLEN;
          pos_d   = '0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
      TAG_SYMLEN: begin
        if ((byte_i == 8'd0) || ({1'b0, byte_i} > 9'(SYMBOL_MAX))) begin
          fault_d = 1'b1;
          phase_d = TAG_EXCESS;
        end else begin
          sym_len_d = SymW'(byte_i);
          phase_d   = TAG_SYMBOL;
        end
        pos_d = '0;
      end
      TAG_SYMBOL: begin
        if (!char_ok) begin
          fault_d = 1'b1;
        end
        if (pos_inc >= (PosW+1)'(sym_len_q)) begin
          phase_d = TAG_DECIMALS;
          pos_d   = '0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
      TAG_DECIMALS: begin
        decimals_d = byte_i;
        phase_d    = TAG_CUSTODY;
        pos_d      = '0;
      end
      TAG_CUSTODY: begin
        custody_d = byte_i;
        phase_d   = TAG_REFLEN;
        pos_d     = '0;
      end
      TAG_REFLEN: begin
        if (pos_q == '0) begin
          ref_high_d = byte_i;
          pos_d      = PosW'(1);
        end else begin
          pos_d = '0;
          if ((ref_value == 16'd0) || ({1'b0, ref_value} > 17'(REF_MAX))) begin
            fault_d = 1'b1;
            phase_d = TAG_EXCESS;
          end else begin
            ref_len_d = RefW'(ref_value);
            phase_d   = TAG_REF;
          end
        end
      end
      TAG_REF: begin
        if (pos_inc >= (PosW+1)'(ref_len_q)) begin
          phase_d = TAG_PAUSED;
          pos_d   = '0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
      TAG_PAUSED: begin
        if (byte_i > 8'd1) begin
          fault_d = 1'b1;
        end else begin
          paused_d = byte_i[0];
        end
        phase_d = TAG_EXCESS;
        pos_d   = '0;
      end
      default: begin
        // Excess bytes: always a fault, index saturates.
        fault_d = 1'b1;
        phase_d = TAG_EXCESS;
        if (pos_q < PosW'(IdxMax)) begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
    endcase
  end

  // Result fields; decoded values only for a complete, clean record.
  assign ok = last_i && !fault_d && (phase_q == TAG_PAUSED);

  always_comb begin
    result_o.tag       = (phase_q > TAG_PAUSED) ? TAG_EXCESS : phase_q;
    result_o.index     = pos_q[IdxW-1:0];
    result_o.data      = byte_i;
    result_o.done      = last_i;
    result_o.ok        = ok;
    result_o.sym_count = ok ? SymCntW'(sym_len_q) : '0;
    result_o.decimals  = ok ? decimals_q : '0;
    result_o.custody   = ok ? custody_q : '0;
    result_o.ref_count = ok ? RefCntW'(ref_len_q) : '0;
    result_o.paused    = ok ? paused_d : 1'b0;
  end

  // State registers; the final byte returns the parser to its reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= TAG_ID;
      pos_q      <= '0;
      sym_len_q  <= '0;
      ref_high_q <= '0;
      ref_len_q  <= '0;
      decimals_q <= '0;
      custody_q  <= '0;
      paused_q   <= 1'b0;
      fault_q    <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= TAG_ID;
        pos_q      <= '0;
        sym_len_q  <= '0;
        ref_high_q <= '0;
        ref_len_q  <= '0;
        decimals_q <= '0;
        custody_q  <= '0;
        paused_q   <= 1'b0;
        fault_q    <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        sym_len_q  <= sym_len_d;
        ref_high_q <= ref_high_d;
        ref_len_q  <= ref_len_d;
        decimals_q <= decimals_d;
        custody_q  <= custody_d;
        paused_q   <= paused_d;
        fault_q    <= fault_d;
      end
    end
  end

endmodule
`default_nettype wire

### bench/asset_record_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asset_record_stream_parser_tb
// Self-checking bench for the asset record parser. Whole records are sent
// byte by byte on the slave stream while an in-bench parser works out the
// tag, index and summary that each byte should produce; every master stream
// transfer is checked field by field against the oldest expectation. Clean,
// malformed, truncated and overlong records are covered, first directed and
// then at random, with random idling on both sides for most of the run.
// ----------------------------------------------------------------------------
module asset_record_stream_parser_tb;
  import arsp_pkg::*;

  localparam int unsigned SymbolMax = 16;
  localparam int unsigned RefMax    = 512;

  // Character class bounds for symbol bytes.
  localparam logic [7:0] CharUpperA = "A";
  localparam logic [7:0] CharUpperZ = "Z";
  localparam logic [7:0] CharDigit0 = "0";
  localparam logic [7:0] CharDigit9 = "9";

  // Record offsets that do not depend on the symbol length.
  localparam int unsigned SymLenPos = IdBytes;
  localparam int unsigned SymPos    = IdBytes + 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TdataOutW-1:0] m_axis_tdata;
  logic [3:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // Idling odds in percent, per byte sent and per receiver cycle; zero turns idling off.
  int tx_gap_pct   = 15;
  int rx_stall_pct = 15;

  int error_count     = 0;
  int bytes_sent      = 0;
  int records_sent    = 0;
  int results_checked = 0;

  arsp_result_t expected_results[$];
  logic [7:0]   record_bytes[$];

  always #1 clk_i = ~clk_i;

  asset_record_stream_parser #(
    .SYMBOL_MAX(SymbolMax),
    .REF_MAX   (RefMax)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Parser state kept by the bench.
  // --------------------------------------------------------------------------
  arsp_tag_e  rec_phase;
  logic [9:0] rec_pos;
  logic [4:0] rec_sym_len;
  logic [7:0] rec_ref_high;
  logic [9:0] rec_ref_len;
  logic [7:0] rec_decimals;
  logic [7:0] rec_custody;
  logic       rec_paused;
  logic       rec_fault;

  function automatic void clear_record_state();
    rec_phase    = TAG_ID;
    rec_pos      = '0;
    rec_sym_len  = '0;
    rec_ref_high = '0;
    rec_ref_len  = '0;
    rec_decimals = '0;
    rec_custody  = '0;
    rec_paused   = 1'b0;
    rec_fault    = 1'b0;
  endfunction

  function automatic bit is_symbol_char(logic [7:0] c);
    return (c >= CharUpperA && c <= CharUpperZ) || (c >= CharDigit0 && c <= CharDigit9);
  endfunction

  // Advances the record state by one byte and returns the result it causes.
  function automatic arsp_result_t parse_byte(logic [7:0] b, logic last);
    arsp_result_t res;
    arsp_tag_e    tag;
    logic [9:0]   idx;
    logic [15:0]  ref_len;
    logic         ok;
    tag     = rec_phase;
    idx     = rec_pos;
    ref_len = '0;
    case (rec_phase)
      TAG_ID: begin
        rec_pos = rec_pos + 10'd1;
        if (rec_pos >= IdBytes) begin
          rec_phase = TAG_SYMLEN;
          rec_pos   = '0;
        end
      end
      TAG_SYMLEN: begin
        if (b == 8'd0 || b > SymbolMax) begin
          rec_fault = 1'b1;
          rec_phase = TAG_EXCESS;
        end else begin
          rec_sym_len = b[4:0];
          rec_phase   = TAG_SYMBOL;
        end
        rec_pos = '0;
      end
      TAG_SYMBOL: begin
        if (!is_symbol_char(b)) rec_fault = 1'b1;
        rec_pos = rec_pos + 10'd1;
        if (rec_pos >= rec_sym_len) begin
          rec_phase = TAG_DECIMALS;
          rec_pos   = '0;
        end
      end
      TAG_DECIMALS: begin
        rec_decimals = b;
        rec_phase    = TAG_CUSTODY;
        rec_pos      = '0;
      end
      TAG_CUSTODY: begin
        rec_custody = b;
        rec_phase   = TAG_REFLEN;
        rec_pos     = '0;
      end
      TAG_REFLEN: begin
        // Big-endian length: high byte first, checked once the low byte lands.
        if (rec_pos == 10'd0) begin
          rec_ref_high = b;
          rec_pos      = 10'd1;
        end else begin
          ref_len = {rec_ref_high, b};
          rec_pos = '0;
          if (ref_len == 16'd0 || ref_len > RefMax) begin
            rec_fault = 1'b1;
            rec_phase = TAG_EXCESS;
          end else begin
            rec_ref_len = ref_len[9:0];
            rec_phase   = TAG_REF;
          end
        end
      end
      TAG_REF: begin
        rec_pos = rec_pos + 10'd1;
        if (rec_pos >= rec_ref_len) begin
          rec_phase = TAG_PAUSED;
          rec_pos   = '0;
        end
      end
      TAG_PAUSED: begin
        if (b > 8'd1) rec_fault = 1'b1;
        else rec_paused = b[0];
        rec_phase = TAG_EXCESS;
        rec_pos   = '0;
      end
      default: begin
        // Anything past the layout is excess; its index saturates.
        rec_fault = 1'b1;
        if (rec_pos < IdxMax) rec_pos = rec_pos + 10'd1;
      end
    endcase
    if (tag == TAG_EXCESS && idx > IdxMax) idx = IdxMax;

    ok = last && !rec_fault && tag == TAG_PAUSED;

    res           = '0;
    res.tag       = tag;
    res.index     = idx[IdxW-1:0];
    res.data      = b;
    res.done      = last;
    res.ok        = ok;
    if (ok) begin
      res.sym_count = rec_sym_len;
      res.decimals  = rec_decimals;
      res.custody   = rec_custody;
      res.ref_count = rec_ref_len;
      res.paused    = rec_paused;
    end
    if (last) clear_record_state();
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Record building.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] random_symbol_char();
    int unsigned k;
    k = $urandom_range(0, 35);
    return (k < 26) ? 8'(CharUpperA + k) : 8'(CharDigit0 + k - 26);
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (is_symbol_char(c)) c = 8'($urandom);
    return c;
  endfunction

  // Fills record_bytes with a well-formed record with random identifier,
  // symbol and reference contents.
  function automatic void make_record(int unsigned sym_len, int unsigned ref_len,
                                      logic [7:0] decimals, logic [7:0] custody,
                                      logic [7:0] paused);
    record_bytes.delete();
    repeat (IdBytes) record_bytes.push_back(8'($urandom));
    record_bytes.push_back(8'(sym_len));
    repeat (sym_len) record_bytes.push_back(random_symbol_char());
    record_bytes.push_back(decimals);
    record_bytes.push_back(custody);
    record_bytes.push_back(8'(ref_len >> 8));
    record_bytes.push_back(8'(ref_len));
    repeat (ref_len) record_bytes.push_back(8'($urandom));
    record_bytes.push_back(paused);
  endfunction

  function automatic void cut_record(int unsigned keep);
    while (record_bytes.size() > keep) void'(record_bytes.pop_back());
  endfunction

  // --------------------------------------------------------------------------
  // Sender side: one byte per transfer, with optional idle bursts before it.
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_record();
    for (int i = 0; i < record_bytes.size(); i++) begin
      send_byte(record_bytes[i], i == record_bytes.size() - 1);
    end
    records_sent++;
  endtask

  // Receiver side: random stall bursts while the odds allow them.
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking: each result transfer against the oldest expectation, and each
  // accepted byte through the bench parser.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    arsp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no byte outstanding: tuser %0d, tdata 0x%0h",
               m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("field_tag", 16'(want.tag), 16'(m_axis_tuser));
        check_field("field_index", 16'(want.index), 16'(m_axis_tdata[8:0]));
        check_field("byte_out", 16'(want.data), 16'(m_axis_tdata[16:9]));
        check_field("record_done", 16'(want.done), 16'(m_axis_tlast));
        check_field("record_ok", 16'(want.ok), 16'(m_axis_tdata[17]));
        check_field("symbol_count", 16'(want.sym_count), 16'(m_axis_tdata[22:18]));
        check_field("decimals_out", 16'(want.decimals), 16'(m_axis_tdata[30:23]));
        check_field("custody_out", 16'(want.custody), 16'(m_axis_tdata[38:31]));
        check_field("reference_count", 16'(want.ref_count), 16'(m_axis_tdata[48:39]));
        check_field("paused_out", 16'(want.paused), 16'(m_axis_tdata[49]));
        results_checked++;
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(parse_byte(s_axis_tdata, s_axis_tlast));
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Canonical records at the length and value extremes.
  task automatic test_clean_records();
    make_record(1, 1, 8'd0, 8'd0, 8'd0);
    send_record();
    // Longest symbol made of the class boundary characters.
    make_record(SymbolMax, 1, 8'hFF, 8'hFF, 8'd1);
    for (int i = 0; i < SymbolMax; i++) begin
      case (i % 4)
        0:       record_bytes[SymPos + i] = CharUpperA;
        1:       record_bytes[SymPos + i] = CharUpperZ;
        2:       record_bytes[SymPos + i] = CharDigit0;
        default: record_bytes[SymPos + i] = CharDigit9;
      endcase
    end
    send_record();
    // Longest reference; its length also needs the high byte.
    make_record(1, RefMax, 8'h12, 8'h80, 8'd1);
    send_record();
  endtask

  // Field values that the layout rejects.
  task automatic test_malformed_fields();
    logic [7:0]  bad_lengths[3] = '{8'd0, 8'd17, 8'd255};
    logic [7:0]  bad_chars[7]   = '{"@", "[", "/", ":", 8'h00, 8'hFF, "a"};
    logic [15:0] bad_refs[3]    = '{16'd0, 16'd513, 16'hFFFF};
    logic [7:0]  bad_paused[2]  = '{8'd2, 8'd255};
    int unsigned ref_pos;
    // Symbol length out of range: the rest of the record becomes excess.
    foreach (bad_lengths[i]) begin
      make_record(4, 4, 8'd6, 8'd2, 8'd0);
      record_bytes[SymLenPos] = bad_lengths[i];
      cut_record(SymLenPos + 2);
      send_record();
    end
    // The illegal characters next to each class boundary, plus 0x00, 0xFF and a lowercase letter, in one symbol.
    make_record(7, 1, 8'd8, 8'd3, 8'd1);
    foreach (bad_chars[i]) record_bytes[SymPos + i] = bad_chars[i];
    send_record();
    // A single bad character among good ones.
    make_record(6, 1, 8'd9, 8'd4, 8'd0);
    record_bytes[SymPos + 3] = random_bad_char();
    send_record();
    // Reference length out of range.
    foreach (bad_refs[i]) begin
      make_record(1, 1, 8'd2, 8'd7, 8'd1);
      ref_pos = SymPos + 1 + 2;
      record_bytes[ref_pos]     = bad_refs[i][15:8];
      record_bytes[ref_pos + 1] = bad_refs[i][7:0];
      send_record();
    end
    // Paused byte above one.
    foreach (bad_paused[i]) begin
      make_record(1, 1, 8'd1, 8'd1, bad_paused[i]);
      send_record();
    end
  endtask

  // Final byte landing in the fields ahead of the paused byte, all but the symbol length.
  task automatic test_truncated_records();
    // With a 1-byte symbol and 1-byte reference: id 0-31, symlen 32,
    // symbol 33, decimals 34, custody 35, length 36-37, reference 38.
    int unsigned cut_sizes[8] = '{1, 20, 33, 34, 35, 36, 37, 38};
    foreach (cut_sizes[i]) begin
      make_record(1, 1, 8'd5, 8'd5, 8'd1);
      cut_record(cut_sizes[i] + ((cut_sizes[i] >= 33) ? 1 : 0));
      send_record();
    end
  endtask

  // Bytes past the paused byte, including a run long enough to saturate
  // the excess index.
  task automatic test_overlong_records();
    make_record(1, 1, 8'd4, 8'd9, 8'd0);
    record_bytes.push_back(8'($urandom));
    send_record();
    make_record(1, 1, 8'd0, 8'd0, 8'd1);
    repeat (514) record_bytes.push_back(8'($urandom));
    send_record();
  endtask

  // Mostly well-formed records with random content, the rest broken or noise.
  task automatic test_random_records();
    int          goal;
    int          quiet_from;
    int unsigned kind;
    int unsigned sym_len;
    int unsigned ref_len;
    int unsigned ref_pos;
    logic [15:0] bad_ref;
    goal       = 1650;
    quiet_from = goal - 250;
    do begin
      // Idling level changes per record, including stretches without any;
      // the closing stretch runs at full rate.
      if (bytes_sent >= quiet_from) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 5;
          default: tx_gap_pct = 25;
        endcase
        case ($urandom_range(0, 3))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 5;
          default: rx_stall_pct = 25;
        endcase
      end

      sym_len = $urandom_range(1, SymbolMax);
      ref_len = ($urandom_range(0, 24) == 0) ? $urandom_range(25, 128)
                                              : $urandom_range(1, 24);
      make_record(sym_len, ref_len, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 1)));
      ref_pos = SymPos + sym_len + 2;
      kind    = $urandom_range(0, 99);
      if (kind < 65) begin
        // Well-formed as built.
      end else if (kind < 72) begin
        record_bytes[SymLenPos] = ($urandom_range(0, 1) == 0) ? 8'd0
                                                              : 8'($urandom_range(17, 255));
      end else if (kind < 78) begin
        record_bytes[SymPos + $urandom_range(0, sym_len - 1)] = random_bad_char();
      end else if (kind < 83) begin
        bad_ref = ($urandom_range(0, 1) == 0) ? 16'd0
                                              : 16'($urandom_range(RefMax + 1, 65535));
        record_bytes[ref_pos]     = bad_ref[15:8];
        record_bytes[ref_pos + 1] = bad_ref[7:0];
      end else if (kind < 88) begin
        record_bytes[record_bytes.size() - 1] = 8'($urandom_range(2, 255));
      end else if (kind < 94) begin
        cut_record($urandom_range(1, record_bytes.size() - 1));
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 8)) record_bytes.push_back(8'($urandom));
      end else begin
        record_bytes.delete();
        repeat ($urandom_range(1, 60)) record_bytes.push_back(8'($urandom));
      end
      send_record();
    end while (bytes_sent < goal);
  endtask

  // --------------------------------------------------------------------------
  // Sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    clear_record_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clean_records();
    test_malformed_fields();
    test_truncated_records();
    test_overlong_records();
    test_random_records();

    // Let every outstanding byte come back, then keep watching for anything
    // the parser should not have produced.
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d records in %0d bytes and checked %0d results.",
             records_sent, bytes_sent, results_checked);
    $display("Records were clean, malformed in each field, cut short or overlong.");
    if (error_count == 0) begin
      $display("asset_record_stream_parser test passed");
    end else begin
      $display("asset_record_stream_parser test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("asset_record_stream_parser test failed");
    $finish;
  end

endmodule

### sim.f
sv/arsp_pkg.sv
sv/arsp_parser.sv
sv/asset_record_stream_parser.sv
bench/asset_record_stream_parser_tb.sv
